/* hw/rtl/maa_pkg.sv */
`timescale 1ns / 1ps

package maa_pkg;

    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_J = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_K = 2'd1;

    localparam logic [WORD_W-1:0] OR_MASK_F  = 32'h0204_0801;
    localparam logic [WORD_W-1:0] OR_MASK_G  = 32'h0080_4021;
    localparam logic [WORD_W-1:0] AND_MASK_F = 32'hBFEF_7FDF;
    localparam logic [WORD_W-1:0] AND_MASK_G = 32'h7DFE_FBFF;
    localparam logic [7:0]        BYTE_ONES  = 8'hFF;

    typedef enum logic [3:0] {
        OP_J1, OP_K1, OP_Q, OP_A2, OP_B2, OP_TA, OP_TB, OP_XAB, OP_X, OP_Y, OP_F, OP_G
    } opnd_t;

    typedef enum logic [1:0] {RED_M1, RED_M2, RED_M2A} red_t;

    typedef enum logic [2:0] {D_A2, D_B2, D_TA, D_TB, D_H5, D_X, D_Y} dst_t;

    typedef enum logic [2:0] {H_4, H_6, H_7, H_8, H_9} hreg_t;

    typedef enum logic [1:0] {SRC_WORD, SRC_S, SRC_T} src_t;

    typedef struct packed {
        logic  bp_load;
        logic  mul_en;
        opnd_t a_sel;
        opnd_t b_sel;
        logic  red_en;
        red_t  red_op;
        dst_t  dst;
        logic  h_en;
        hreg_t h_dst;
        logic  kc_load;
        logic  in_load;
        logic  chain_init;
        logic  prep_en;
        src_t  src;
        logic  z_en;
    } cmd_t;

    localparam cmd_t CMD_NOP = '0;

endpackage

/* hw/rtl/maa_datapath.sv */
`timescale 1ns / 1ps

module maa_datapath
    import maa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    input  logic [WORD_W-1:0]    s_message_word,
    input  cmd_t                 cmd,
    output logic [WORD_W-1:0]    mac_value
);

    logic [WORD_W-1:0] key_j_reg, key_k_reg;
    logic [WORD_W-1:0] j1_reg, k1_reg, q_reg;
    logic [WORD_W-1:0] a2_reg, b2_reg, ta_reg, tb_reg;
    logic [WORD_W-1:0] h4_reg, h5_reg, h6_reg, h7_reg, h8_reg, h9_reg;
    logic [WORD_W-1:0] x0_reg, y0_reg, v0_reg, w_reg, s_reg, t_reg;
    logic [WORD_W-1:0] x_reg, y_reg, v_reg, f_reg, g_reg, word_reg, mac_reg;
    logic [2*WORD_W-1:0] prod_reg;

    logic [WORD_W-1:0] opa, opb, red_val, src_val, v_rot, e_val, xw, yw;
    logic [71:0] bp_key, bp_a, bp_b, bp_c;
    logic [8:0]  p_inc;

    function automatic logic [71:0] byte_pattern(input logic [63:0] joined);
        logic [63:0] outv;
        logic [7:0]  p;
        logic [7:0]  b;
        outv = '0;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            b = joined[63-8*i -: 8];
            p = {p[6:0], 1'b0};
            if (b == 8'h00 || b == BYTE_ONES) begin
                p = p + 8'd1;
                b = b ^ p;
            end
            outv = {outv[55:0], b};
        end
        return {outv, p};
    endfunction

    function automatic logic [WORD_W-1:0] red_one(input logic [63:0] pr);
        logic [WORD_W:0] s;
        s = {1'b0, pr[63:32]} + {1'b0, pr[31:0]};
        return s[WORD_W-1:0] + WORD_W'(s[WORD_W]);
    endfunction

    function automatic logic [WORD_W-1:0] red_two(input logic [63:0] pr);
        logic [WORD_W:0]   d;
        logic [WORD_W-1:0] f;
        logic [WORD_W:0]   s;
        d = {pr[63:32], 1'b0};
        f = d[WORD_W-1:0] + {30'd0, d[WORD_W], 1'b0};
        s = {1'b0, f} + {1'b0, pr[31:0]};
        return s[WORD_W-1:0] + {30'd0, s[WORD_W], 1'b0};
    endfunction

    function automatic logic [WORD_W-1:0] red_two_a(input logic [63:0] pr);
        logic [WORD_W:0] s;
        s = {1'b0, pr[62:32], 1'b0} + {1'b0, pr[31:0]};
        return s[WORD_W-1:0] + {30'd0, s[WORD_W], 1'b0};
    endfunction

    always_comb begin
        case (cmd.a_sel)
            OP_J1:   opa = j1_reg;
            OP_K1:   opa = k1_reg;
            OP_Q:    opa = q_reg;
            OP_A2:   opa = a2_reg;
            OP_B2:   opa = b2_reg;
            OP_TA:   opa = ta_reg;
            OP_TB:   opa = tb_reg;
            OP_XAB:  opa = ta_reg ^ tb_reg;
            OP_X:    opa = x_reg;
            OP_Y:    opa = y_reg;
            OP_F:    opa = f_reg;
            OP_G:    opa = g_reg;
            default: opa = '0;
        endcase
        case (cmd.b_sel)
            OP_J1:   opb = j1_reg;
            OP_K1:   opb = k1_reg;
            OP_Q:    opb = q_reg;
            OP_A2:   opb = a2_reg;
            OP_B2:   opb = b2_reg;
            OP_TA:   opb = ta_reg;
            OP_TB:   opb = tb_reg;
            OP_XAB:  opb = ta_reg ^ tb_reg;
            OP_X:    opb = x_reg;
            OP_Y:    opb = y_reg;
            OP_F:    opb = f_reg;
            OP_G:    opb = g_reg;
            default: opb = '0;
        endcase
        case (cmd.red_op)
            RED_M1:  red_val = red_one(prod_reg);
            RED_M2:  red_val = red_two(prod_reg);
            default: red_val = red_two_a(prod_reg);
        endcase
        case (cmd.src)
            SRC_S:   src_val = s_reg;
            SRC_T:   src_val = t_reg;
            default: src_val = word_reg;
        endcase
    end

    assign bp_key = byte_pattern({key_j_reg, key_k_reg});
    assign bp_a   = byte_pattern({h4_reg, h5_reg});
    assign bp_b   = byte_pattern({h6_reg, h7_reg});
    assign bp_c   = byte_pattern({h8_reg, h9_reg});
    assign p_inc  = {1'b0, bp_key[7:0]} + 9'd1;

    assign v_rot = {v_reg[WORD_W-2:0], v_reg[WORD_W-1]};
    assign e_val = v_rot ^ w_reg;
    assign xw    = x_reg ^ src_val;
    assign yw    = y_reg ^ src_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_j_reg <= '0;
            key_k_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_KEY_J) key_j_reg <= cfg_wdata;
            if (cfg_index == REG_KEY_K) key_k_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bp_load) begin
            j1_reg <= bp_key[71:40];
            k1_reg <= bp_key[39:8];
            q_reg  <= {14'd0, 18'(p_inc) * 18'(p_inc)};
        end
        if (cmd.mul_en) prod_reg <= opa * opb;
        if (cmd.red_en) begin
            case (cmd.dst)
                D_A2:    a2_reg <= red_val;
                D_B2:    b2_reg <= red_val;
                D_TA:    ta_reg <= red_val;
                D_TB:    tb_reg <= red_val;
                D_H5:    h5_reg <= red_val;
                D_X:     x_reg  <= red_val;
                default: y_reg  <= red_val;
            endcase
        end
        if (cmd.h_en) begin
            case (cmd.h_dst)
                H_4:     h4_reg <= ta_reg ^ tb_reg;
                H_6:     h6_reg <= ta_reg ^ tb_reg;
                H_7:     h7_reg <= ta_reg ^ tb_reg;
                H_8:     h8_reg <= ta_reg ^ tb_reg;
                default: h9_reg <= ta_reg ^ tb_reg;
            endcase
        end
        if (cmd.kc_load) begin
            x0_reg <= bp_a[71:40];
            y0_reg <= bp_a[39:8];
            v0_reg <= bp_b[71:40];
            w_reg  <= bp_b[39:8];
            s_reg  <= bp_c[71:40];
            t_reg  <= bp_c[39:8];
        end
        if (cmd.in_load) word_reg <= s_message_word;
        if (cmd.chain_init) begin
            x_reg <= x0_reg;
            y_reg <= y0_reg;
            v_reg <= v0_reg;
        end
        if (cmd.prep_en) begin
            v_reg <= v_rot;
            x_reg <= xw;
            y_reg <= yw;
            f_reg <= ((e_val + yw) | OR_MASK_F) & AND_MASK_F;
            g_reg <= ((e_val + xw) | OR_MASK_G) & AND_MASK_G;
        end
        if (cmd.z_en) mac_reg <= x_reg ^ y_reg;
    end

    assign mac_value = mac_reg;

endmodule

/* hw/rtl/maa_controller.sv */
`timescale 1ns / 1ps

module maa_controller
    import maa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic key_wr,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_last_word,
    input  logic s_empty_message,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_EXPAND = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_PREP   = 7'b0000100,
        ST_MX     = 7'b0001000,
        ST_RXMY   = 7'b0010000,
        ST_RY     = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    localparam logic [5:0] EXP_LAST = 6'd44;

    state_t     state_reg, state_next;
    logic [5:0] step_reg, step_next;
    src_t       src_reg, src_next;
    logic       last_reg, last_next;
    logic       inmsg_reg, inmsg_next;
    logic       mv_reg, mv_next;

    function automatic cmd_t c_mul(input opnd_t a, input opnd_t b);
        cmd_t c;
        c = CMD_NOP;
        c.mul_en = 1'b1;
        c.a_sel = a;
        c.b_sel = b;
        return c;
    endfunction

    function automatic cmd_t c_red(input red_t op, input dst_t d);
        cmd_t c;
        c = CMD_NOP;
        c.red_en = 1'b1;
        c.red_op = op;
        c.dst = d;
        return c;
    endfunction

    function automatic cmd_t c_hx(input hreg_t h);
        cmd_t c;
        c = CMD_NOP;
        c.h_en = 1'b1;
        c.h_dst = h;
        return c;
    endfunction

    function automatic cmd_t exp_cmd(input logic [5:0] step);
        cmd_t c;
        c = CMD_NOP;
        case (step)
            6'd0:  c.bp_load = 1'b1;
            6'd1:  c = c_mul(OP_J1, OP_J1);
            6'd2:  c = c_red(RED_M1, D_A2);
            6'd3:  c = c_mul(OP_J1, OP_J1);
            6'd4:  c = c_red(RED_M2, D_B2);
            6'd5:  c = c_mul(OP_A2, OP_A2);
            6'd6:  c = c_red(RED_M1, D_TA);
            6'd7:  c = c_mul(OP_B2, OP_B2);
            6'd8:  c = c_red(RED_M2, D_TB);
            6'd9:  c = c_hx(H_4);
            6'd10: c = c_mul(OP_A2, OP_TA);
            6'd11: c = c_red(RED_M1, D_TA);
            6'd12: c = c_mul(OP_B2, OP_TB);
            6'd13: c = c_red(RED_M2, D_TB);
            6'd14: c = c_hx(H_6);
            6'd15: c = c_mul(OP_A2, OP_TA);
            6'd16: c = c_red(RED_M1, D_TA);
            6'd17: c = c_mul(OP_B2, OP_TB);
            6'd18: c = c_red(RED_M2, D_TB);
            6'd19: c = c_hx(H_8);
            6'd20: c = c_mul(OP_K1, OP_K1);
            6'd21: c = c_red(RED_M1, D_A2);
            6'd22: c = c_mul(OP_K1, OP_K1);
            6'd23: c = c_red(RED_M2, D_B2);
            6'd24: c = c_mul(OP_A2, OP_A2);
            6'd25: c = c_red(RED_M1, D_TA);
            6'd26: c = c_mul(OP_B2, OP_B2);
            6'd27: c = c_red(RED_M2, D_TB);
            6'd28: c = c_mul(OP_K1, OP_TA);
            6'd29: c = c_red(RED_M1, D_TA);
            6'd30: c = c_mul(OP_K1, OP_TB);
            6'd31: c = c_red(RED_M2, D_TB);
            6'd32: c = c_mul(OP_XAB, OP_Q);
            6'd33: c = c_red(RED_M2, D_H5);
            6'd34: c = c_mul(OP_A2, OP_TA);
            6'd35: c = c_red(RED_M1, D_TA);
            6'd36: c = c_mul(OP_B2, OP_TB);
            6'd37: c = c_red(RED_M2, D_TB);
            6'd38: c = c_hx(H_7);
            6'd39: c = c_mul(OP_A2, OP_TA);
            6'd40: c = c_red(RED_M1, D_TA);
            6'd41: c = c_mul(OP_B2, OP_TB);
            6'd42: c = c_red(RED_M2, D_TB);
            6'd43: c = c_hx(H_9);
            6'd44: c.kc_load = 1'b1;
            default: c = CMD_NOP;
        endcase
        return c;
    endfunction

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        src_next   = src_reg;
        last_next  = last_reg;
        inmsg_next = inmsg_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = CMD_NOP;
        unique case (state_reg)
            ST_EXPAND: begin
                cmd = exp_cmd(step_reg);
                if (step_reg == EXP_LAST) begin
                    state_next = ST_IDLE;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 6'd1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.in_load    = 1'b1;
                    cmd.chain_init = !inmsg_reg;
                    inmsg_next     = !s_last_word;
                    last_next      = s_last_word;
                    src_next       = (s_last_word && s_empty_message) ? SRC_S : SRC_WORD;
                    state_next     = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep_en = 1'b1;
                cmd.src     = src_reg;
                state_next  = ST_MX;
            end
            ST_MX: begin
                cmd        = c_mul(OP_X, OP_F);
                state_next = ST_RXMY;
            end
            ST_RXMY: begin
                cmd        = c_red(RED_M1, D_X);
                cmd.mul_en = 1'b1;
                cmd.a_sel  = OP_Y;
                cmd.b_sel  = OP_G;
                state_next = ST_RY;
            end
            ST_RY: begin
                cmd = c_red(RED_M2A, D_Y);
                unique case (src_reg)
                    SRC_WORD: begin
                        src_next   = SRC_S;
                        state_next = last_reg ? ST_PREP : ST_IDLE;
                    end
                    SRC_S: begin
                        src_next   = SRC_T;
                        state_next = ST_PREP;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    cmd.z_en   = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_EXPAND;
        endcase
        if (key_wr) begin
            state_next = ST_EXPAND;
            step_next  = '0;
            inmsg_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_EXPAND;
            step_reg  <= '0;
            src_reg   <= SRC_WORD;
            last_reg  <= 1'b0;
            inmsg_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            src_reg   <= src_next;
            last_reg  <= last_next;
            inmsg_reg <= inmsg_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.z_en |-> (!mv_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_chain_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !inmsg_reg) |-> cmd.chain_init)
        else $error("message started without loading the chain");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output state");

endmodule

/* hw/rtl/maa_message_authenticator_top.sv */
`timescale 1ns / 1ps

// MAA message authenticator. After reset and after every write of key_j or key_k the
// block expands the key in the ST_EXPAND state, with s_ready low; a word that is being
// absorbed then is abandoned. Each word is accepted in ST_IDLE and absorbed by one
// round of ST_PREP, ST_MX, ST_RXMY and ST_RY; a last word adds two rounds for S and T
// and the ST_OUT state to register Z (an empty last word is not itself absorbed).
// Rounds are serialised by the single shared 32x32 multiplier, which every round uses
// twice, with a product register between multiplication and reduction.
module maa_message_authenticator_top
    import maa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_W-1:0]    s_message_word,
    input  logic                 s_last_word,
    input  logic                 s_empty_message,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [WORD_W-1:0]    m_mac_value
);

    cmd_t cmd;
    logic key_wr;

    assign key_wr = cfg_we && (cfg_index == REG_KEY_J || cfg_index == REG_KEY_K);

    maa_controller u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .key_wr          (key_wr),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_last_word     (s_last_word),
        .s_empty_message (s_empty_message),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .cmd             (cmd)
    );

    maa_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_message_word (s_message_word),
        .cmd            (cmd),
        .mac_value      (m_mac_value)
    );

endmodule

/* tb/sv/maa_message_authenticator_top_tb.sv */
`timescale 1ns / 1ps

module maa_message_authenticator_top_tb;
    import maa_pkg::*;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              empty;
        logic              has_mac;
        logic [WORD_W-1:0] mac;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [WORD_W-1:0]    s_message_word;
    logic                 s_last_word;
    logic                 s_empty_message;
    logic                 m_valid;
    logic                 m_ready;
    logic [WORD_W-1:0]    m_mac_value;

    logic [31:0] kj, kk;
    logic [31:0] kc_x0, kc_y0, kc_v0, kc_w, kc_s, kc_t;
    logic [31:0] cx, cy, rv;
    bit          busy_msg;
    logic [31:0] mac_queue [$];
    int          errors;
    int          cycles;
    int          macs_seen;
    int          words_sent;
    int          keys_used;
    stim_row_t   directed [$];

    maa_message_authenticator_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_message_word(s_message_word), .s_last_word(s_last_word),
        .s_empty_message(s_empty_message),
        .m_valid(m_valid), .m_ready(m_ready), .m_mac_value(m_mac_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] mul_m1(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        logic [32:0] s;
        p = 64'(a) * 64'(b);
        s = 33'(p[63:32]) + 33'(p[31:0]);
        return s[31:0] + 32'(s[32]);
    endfunction

    function automatic logic [31:0] mul_m2(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        logic [32:0] d, s;
        logic [31:0] f;
        p = 64'(a) * 64'(b);
        d = 33'(p[63:32]) << 1;
        f = d[31:0] + {30'd0, d[32], 1'b0};
        s = 33'(f) + 33'(p[31:0]);
        return s[31:0] + {30'd0, s[32], 1'b0};
    endfunction

    function automatic logic [31:0] mul_m2a(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        logic [31:0] d;
        logic [32:0] s;
        p = 64'(a) * 64'(b);
        d = p[62:32] << 1;
        s = 33'(d) + 33'(p[31:0]);
        return s[31:0] + {30'd0, s[32], 1'b0};
    endfunction

    task automatic spread_bytes(input logic [31:0] a, input logic [31:0] b,
                                output logic [31:0] oa, output logic [31:0] ob,
                                output logic [7:0] pat);
        logic [63:0] joined, outv;
        logic [7:0]  bt;
        joined = {a, b};
        outv = '0;
        pat = '0;
        for (int i = 0; i < 8; i++) begin
            bt = joined[63 - 8*i -: 8];
            pat = pat << 1;
            if (bt == 8'h00 || bt == BYTE_ONES) begin
                pat = pat + 8'd1;
                bt = bt ^ pat;
            end
            outv = {outv[55:0], bt};
        end
        oa = outv[63:32];
        ob = outv[31:0];
    endtask

    task automatic expand_key();
        logic [31:0] j1, k1, q;
        logic [7:0]  p, unused;
        logic [31:0] ja2, jb2, ja4, jb4, ja6, jb6, ja8, jb8;
        logic [31:0] ka2, kb2, ka4, kb4, ka5, kb5, ka7, kb7, ka9, kb9;
        spread_bytes(kj, kk, j1, k1, p);
        q = (32'd1 + 32'(p)) * (32'd1 + 32'(p));
        ja2 = mul_m1(j1, j1);    jb2 = mul_m2(j1, j1);
        ja4 = mul_m1(ja2, ja2);  jb4 = mul_m2(jb2, jb2);
        ja6 = mul_m1(ja2, ja4);  jb6 = mul_m2(jb2, jb4);
        ja8 = mul_m1(ja2, ja6);  jb8 = mul_m2(jb2, jb6);
        ka2 = mul_m1(k1, k1);    kb2 = mul_m2(k1, k1);
        ka4 = mul_m1(ka2, ka2);  kb4 = mul_m2(kb2, kb2);
        ka5 = mul_m1(k1, ka4);   kb5 = mul_m2(k1, kb4);
        ka7 = mul_m1(ka2, ka5);  kb7 = mul_m2(kb2, kb5);
        ka9 = mul_m1(ka2, ka7);  kb9 = mul_m2(kb2, kb7);
        spread_bytes(ja4 ^ jb4, mul_m2(ka5 ^ kb5, q), kc_x0, kc_y0, unused);
        spread_bytes(ja6 ^ jb6, ka7 ^ kb7, kc_v0, kc_w, unused);
        spread_bytes(ja8 ^ jb8, ka9 ^ kb9, kc_s, kc_t, unused);
    endtask

    task automatic absorb(input logic [31:0] word);
        logic [31:0] e, f, g;
        rv = {rv[30:0], rv[31]};
        e = rv ^ kc_w;
        cx = cx ^ word;
        cy = cy ^ word;
        f = ((e + cy) | OR_MASK_F) & AND_MASK_F;
        g = ((e + cx) | OR_MASK_G) & AND_MASK_G;
        cx = mul_m1(cx, f);
        cy = mul_m2a(cy, g);
    endtask

    // Returns 1 and the MAC when the word closes a message.
    task automatic predict_mac(input logic [31:0] word, input logic last, input logic empty,
                               output bit produced, output logic [31:0] mac);
        if (!busy_msg) begin
            cx = kc_x0;
            cy = kc_y0;
            rv = kc_v0;
            busy_msg = 1'b1;
        end
        if (!(last && empty)) absorb(word);
        produced = last;
        mac = '0;
        if (last) begin
            absorb(kc_s);
            absorb(kc_t);
            mac = cx ^ cy;
            busy_msg = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("ERROR at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("maa_message_authenticator_top_tb failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            macs_seen <= macs_seen + 1;
            if (mac_queue.size() == 0) begin
                report_mismatch("unexpected mac_value", m_mac_value, '0);
            end else begin
                if (m_mac_value !== mac_queue[0])
                    report_mismatch("mac_value", m_mac_value, mac_queue[0]);
                void'(mac_queue.pop_front());
            end
        end
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            repeat (gap) @(posedge aclk);
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            m_ready <= 1'b0;
        end
    end

    task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx == REG_KEY_J) kj = value;
        if (idx == REG_KEY_K) kk = value;
        if (idx == REG_KEY_J || idx == REG_KEY_K) begin
            expand_key();
            busy_msg = 1'b0;
            keys_used++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (mac_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_word(input logic [31:0] word, input logic last, input logic empty,
                             input bit has_mac, input logic [31:0] want, input bit paced);
        bit          produced;
        logic [31:0] mac;
        int          gap;
        gap = paced ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predict_mac(word, last, empty, produced, mac);
        if (has_mac && produced && mac !== want)
            report_mismatch("predicted mac_value", mac, want);
        if (produced) mac_queue.push_back(mac);
        s_valid         <= 1'b1;
        s_message_word  <= word;
        s_last_word     <= last;
        s_empty_message <= empty;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic random_message(input int len, input bit paced);
        logic [31:0] word;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 5))
                0: word = 32'h0;
                1: word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            send_word(word, i == len - 1,
                      (i == len - 1) ? 1'($urandom_range(0, 4) == 0)
                                     : 1'($urandom_range(0, 1)),
                      1'b0, '0, paced);
        end
    endtask

    initial begin
        logic [31:0] key_values [6];
        bit paced;
        errors = 0; cycles = 0; macs_seen = 0; words_sent = 0; keys_used = 0;
        aresetn = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 1'b0; s_message_word = '0; s_last_word = 1'b0; s_empty_message = 1'b0;
        kj = '0; kk = '0; busy_msg = 1'b0;
        expand_key();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows on the reset key: extremes, empty flag cases, single-word messages.
        directed = '{
            '{32'h0000_0000, 1'b1, 1'b0, 1'b0, '0},
            '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, '0},
            '{32'h1234_5678, 1'b1, 1'b1, 1'b0, '0},
            '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, '0},
            '{32'h0000_0000, 1'b0, 1'b0, 1'b0, '0},
            '{32'h8000_0001, 1'b1, 1'b0, 1'b0, '0},
            '{32'hA5A5_5A5A, 1'b0, 1'b0, 1'b0, '0},
            '{32'hDEAD_BEEF, 1'b1, 1'b1, 1'b0, '0},
            '{32'h7FFF_FFFE, 1'b0, 1'b1, 1'b0, '0},
            '{32'h0000_0001, 1'b1, 1'b0, 1'b0, '0}
        };
        foreach (directed[i])
            send_word(directed[i].word, directed[i].last, directed[i].empty,
                      directed[i].has_mac, directed[i].mac, 1'b1);
        wait_drained();

        // A message abandoned by a key write, plus an unused register index.
        send_word(32'hCAFE_F00D, 1'b0, 1'b0, 1'b0, '0, 1'b0);
        wait_drained();
        write_key(REG_KEY_K + 2'd1, 32'hFFFF_FFFF);
        write_key(REG_KEY_J, 32'hFFFF_FFFF);
        write_key(REG_KEY_K, 32'hFFFF_FFFF);
        send_word(32'h0000_0000, 1'b1, 1'b0, 1'b0, '0, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0, 1'b1);
        wait_drained();

        key_values = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'h8000_0000,
                       32'h0000_0001, 32'hFF00_00FF};
        for (int phase = 0; phase < 12; phase++) begin
            write_key(REG_KEY_J, (phase < 6) ? key_values[phase] : $urandom);
            write_key(REG_KEY_K, (phase < 6) ? key_values[5 - phase] : $urandom);
            while (words_sent < 40 + 66 * (phase + 1)) begin
                paced = (phase % 3) != 1;
                random_message($urandom_range(0, 7) == 0 ? $urandom_range(10, 30)
                                                        : $urandom_range(1, 5), paced);
            end
            wait_drained();
        end

        $display("Sent %0d words under %0d key settings; %0d MACs checked.",
                 words_sent, keys_used, macs_seen);
        if (errors == 0) begin
            $display("maa_message_authenticator_top_tb passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("maa_message_authenticator_top_tb failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/maa_pkg.sv
hw/rtl/maa_datapath.sv
hw/rtl/maa_controller.sv
hw/rtl/maa_message_authenticator_top.sv
tb/sv/maa_message_authenticator_top_tb.sv
